FILE: rtl/core/m4c_pkg.sv
package m4c_pkg;

  localparam int unsigned MaxWidth = 64;
  localparam int unsigned WidthW   = 7;
  localparam int unsigned Slots    = 3;

  // result slots in delivery order
  localparam int unsigned SlotFirst = 0;
  localparam int unsigned SlotMid   = 1;
  localparam int unsigned SlotLast  = 2;

  localparam logic [WidthW-1:0] WidthReset = WidthW'(MaxWidth);

  typedef logic [MaxWidth-1:0] row_t;

  typedef struct packed {
    logic [Slots-1:0] vld;
    row_t             last_w;
    row_t             mid_w;
    row_t             first_w;
  } res_t;

  function automatic logic [WidthW-1:0] eff_width(logic [WidthW-1:0] n);
    logic [WidthW-1:0] w;
    w = n;
    if (w == '0) w = WidthW'(1);
    if (w > WidthW'(MaxWidth)) w = WidthW'(MaxWidth);
    return w;
  endfunction

  function automatic row_t low_mask(logic [WidthW-1:0] n);
    if (n >= WidthW'(MaxWidth)) return '1;
    return (row_t'(1) << n) - row_t'(1);
  endfunction

  // interior columns 1 .. w-2
  function automatic row_t inner_cols(logic [WidthW-1:0] w);
    if (w < WidthW'(3)) return '0;
    return low_mask(w - WidthW'(1)) & ~row_t'(1);
  endfunction

  // columns of neighbor row nb to set for center row c
  function automatic row_t marks(row_t c, row_t nb, row_t inner);
    row_t cr, cl, nr, nl, diff, rgt, lft;
    cr   = c >> 1;
    cl   = c << 1;
    nr   = nb >> 1;
    nl   = nb << 1;
    diff = c ^ nb;
    rgt  = ~(c ^ nr) & diff & (c ^ cr);
    lft  = ~(c ^ nl) & diff & (c ^ cl);
    return (rgt | lft) & inner;
  endfunction

endpackage

FILE: rtl/core/m4c_row_proc.sv
module m4c_row_proc import m4c_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [WidthW-1:0] cfg_wdata_i,
  input  logic              accept_i,
  input  row_t              row_i,
  input  logic              last_i,
  output res_t              res_o
);

  logic [WidthW-1:0] width_q;
  row_t              win_q [4];
  logic [2:0]        cnt_q, cnt_d;

  logic [WidthW-1:0] w_eff;
  row_t              wm, inner, x;
  row_t              r_first, r_mid, r_last;

  always_comb begin
    w_eff = eff_width(width_q);
    wm    = low_mask(w_eff);
    inner = inner_cols(w_eff);
    x     = row_i & wm;

    r_first = win_q[2] | marks(win_q[3], win_q[2], inner);
    if (cnt_q >= 3'd4) r_first = r_first | marks(win_q[1], win_q[2], inner);

    r_mid = win_q[3];
    if (cnt_q >= 3'd3) r_mid = r_mid | marks(win_q[2], win_q[3], inner);

    r_last = x;
    if (cnt_q >= 3'd2) r_last = r_last | marks(win_q[3], x, inner);

    res_o.first_w        = r_first & wm;
    res_o.mid_w          = r_mid & wm;
    res_o.last_w         = r_last & wm;
    res_o.vld[SlotFirst] = cnt_q >= 3'd2;
    res_o.vld[SlotMid]   = last_i && (cnt_q != 3'd0);
    res_o.vld[SlotLast]  = last_i;

    cnt_d = cnt_q;
    if (accept_i) begin
      if (last_i) cnt_d = 3'd0;
      else if (cnt_q < 3'd4) cnt_d = cnt_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WidthReset;
      cnt_q   <= 3'd0;
    end else begin
      if (cfg_we_i) width_q <= cfg_wdata_i;
      cnt_q <= cnt_d;
    end
  end

  // held rows are only read once the row count says they are filled
  always_ff @(posedge clk_i) begin
    if (accept_i && !last_i) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= win_q[3];
      win_q[3] <= x;
    end
  end

endmodule

FILE: rtl/core/m4c_out_buf.sv
module m4c_out_buf import m4c_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic accept_o,
  input  res_t res_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output row_t out_pixels_o,
  output logic out_last_o
);

  logic [Slots-1:0] vld_q, vld_d;
  logic [Slots-1:0] lowest, vld_pop;
  row_t             word_q [Slots];
  logic             pop;

  always_comb begin
    lowest      = vld_q & (~vld_q + Slots'(1));
    out_valid_o = vld_q != '0;
    pop         = out_valid_o && out_ready_i;
    vld_pop     = pop ? (vld_q & ~lowest) : vld_q;
    // a new word may enter as soon as nothing will be left pending
    in_ready_o  = vld_pop == '0;
    accept_o    = in_valid_i && in_ready_o;
    vld_d       = accept_o ? res_i.vld : vld_pop;

    if (lowest[SlotFirst])    out_pixels_o = word_q[SlotFirst];
    else if (lowest[SlotMid]) out_pixels_o = word_q[SlotMid];
    else                      out_pixels_o = word_q[SlotLast];
    out_last_o = lowest[SlotLast];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_o) begin
      word_q[SlotFirst] <= res_i.first_w;
      word_q[SlotMid]   <= res_i.mid_w;
      word_q[SlotLast]  <= res_i.last_w;
    end
  end

endmodule

FILE: rtl/core/m_to_4_connectivity_fill.sv
// Converts an m-connected binary image to a 4-connected one, one row of up to
// 64 pixels per word. Row r leaves once row r+2 has been accepted; the word
// flagged last_row releases the held rows as well, so it produces up to three
// output words, the final one marked by out_last_o. A new row is accepted every
// cycle while the consumer keeps up: each accepted row is processed in one
// pass from the row window into a three-slot result register, and input waits
// only while that register still has words to deliver after the current
// cycle. image_width is written through cfg_we_i / cfg_wdata_i between frames;
// 0 acts as 1 and values above 64 act as 64.
module m_to_4_connectivity_fill import m4c_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [WidthW-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  row_t              row_pixels_i,
  input  logic              last_row_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output row_t              out_pixels_o,
  output logic              out_last_o
);

  logic accept;
  res_t res;

  m4c_row_proc u_proc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .accept_i   (accept),
    .row_i      (row_pixels_i),
    .last_i     (last_row_i),
    .res_o      (res)
  );

  m4c_out_buf u_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .accept_o    (accept),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_pixels_o(out_pixels_o),
    .out_last_o  (out_last_o)
  );

endmodule
